/* rtl/core/frrs_pkg.sv */
// shared types and constants for the functional-unit lane steering block
package frrs_pkg;

	localparam int LANE_COUNT_DEF = 8;
	localparam int FU_TYPES_DEF   = 8;
	localparam int ELEMENTS_DEF   = 8;

	localparam int MASK_W  = 64;
	localparam int FIELD_W = 3;

	localparam logic [MASK_W-1:0] MASK_RESET = '1;

	typedef struct packed {
		logic [FIELD_W-1:0] unit_type;
		logic [FIELD_W-1:0] element_index;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] lane;
		logic               no_lane;
	} rsp_t;

endpackage

/* rtl/core/frrs_ptr_store.sv */
// last-chosen-lane pointer store with per-entry valid bits and registered read
module frrs_ptr_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int LW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [LW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [LW-1:0] wr_data
);

	logic [LW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [LW-1:0]    rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// an entry never written reads as lane zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

/* rtl/core/frrs_pick.sv */
// round-robin lane search starting after the stored pointer
module frrs_pick #(
	parameter int LANE_COUNT = 8,
	parameter int LW         = 3
) (
	input  logic [LW-1:0]         ptr,
	input  logic [LANE_COUNT-1:0] mask,
	output frrs_pkg::rsp_t        pick
);

	always_comb begin
		logic [LW:0] cand;
		pick.lane    = '0;
		pick.no_lane = 1'b1;
		// walk from the furthest step back so the nearest hit wins
		for (int i = LANE_COUNT; i >= 1; i--) begin
			cand = {1'b0, ptr} + (LW+1)'(i);
			if (cand >= (LW+1)'(LANE_COUNT)) begin
				cand = cand - (LW+1)'(LANE_COUNT);
			end
			if (mask[cand[LW-1:0]]) begin
				pick.lane    = frrs_pkg::FIELD_W'(cand);
				pick.no_lane = 1'b0;
			end
		end
	end

endmodule

/* rtl/core/fu_lane_round_robin_steer.sv */
// Steers each instruction (unit type, processing element) to an execution lane by a
// round-robin search over the type's lane mask, starting after the lane last chosen
// for that element and type. One item is accepted per clock while the result side does
// not stall. The pointer store is read at the accept edge into a registered read port,
// the search runs on the registered item, and the result and pointer update are
// registered together as the item leaves the search stage. A back-to-back item for the same
// element and type takes the fresh pointer through a bypass, so the sustained rate is
// one item per cycle whenever the result side does not stall. Pointers start at zero
// after reset with no clearing pass. The mask register is written through cfg_data,
// which is always ready, and should only change while no item is in flight.
module fu_lane_round_robin_steer #(
	parameter int LANE_COUNT = frrs_pkg::LANE_COUNT_DEF,
	parameter int FU_TYPES   = frrs_pkg::FU_TYPES_DEF,
	parameter int ELEMENTS   = frrs_pkg::ELEMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  frrs_pkg::req_t              req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output frrs_pkg::rsp_t              rsp_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [frrs_pkg::MASK_W-1:0] cfg_data
);

	localparam int DEPTH = ELEMENTS * FU_TYPES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(LANE_COUNT);

	logic [frrs_pkg::MASK_W-1:0] lane_masks_q;

	logic            s1_valid;
	frrs_pkg::req_t  req_s1;
	logic            in_range_s1;
	logic [AW-1:0]   slot_s1;
	logic            byp_s1;
	logic [LW-1:0]   byp_lane_s1;

	logic            rsp_valid_q;
	frrs_pkg::rsp_t  rsp_q;

	logic            req_accept;
	logic            s1_adv;
	logic            in_range;
	logic [AW-1:0]   slot;
	logic [LW-1:0]   ptr_rd;
	logic [LW-1:0]   ptr;
	logic [LANE_COUNT-1:0] type_mask;
	frrs_pkg::rsp_t  pick;
	frrs_pkg::rsp_t  result;
	logic            wr_en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_masks_q <= frrs_pkg::MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lane_masks_q <= cfg_data;
		end
	end

	// handshake control
	assign s1_adv     = !rsp_valid_q || !rsp_stall;
	assign req_stall  = s1_valid && !s1_adv;
	assign req_accept = req_valid && !req_stall;

	assign in_range = (int'(req_data.unit_type) < FU_TYPES) &&
	                  (int'(req_data.element_index) < ELEMENTS);
	assign slot = AW'(int'(req_data.element_index) * FU_TYPES + int'(req_data.unit_type));

	assign wr_en = s1_valid && s1_adv && in_range_s1 && !pick.no_lane;

	frrs_ptr_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.LW    (LW)
	) u_ptr_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (req_accept && in_range),
		.rd_addr (slot),
		.rd_data (ptr_rd),
		.wr_en   (wr_en),
		.wr_addr (slot_s1),
		.wr_data (pick.lane[LW-1:0])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			if (req_accept) begin
				s1_valid <= 1'b1;
				// the store read misses a write landing on the same edge
				byp_s1   <= wr_en && (slot_s1 == slot);
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
				byp_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1      <= req_data;
			in_range_s1 <= in_range;
			slot_s1     <= slot;
			byp_lane_s1 <= pick.lane[LW-1:0];
		end
	end

	assign ptr = byp_s1 ? byp_lane_s1 : ptr_rd;

	always_comb begin
		logic [6:0] pos;
		type_mask = '0;
		for (int l = 0; l < LANE_COUNT; l++) begin
			pos = 7'(int'(req_s1.unit_type) * LANE_COUNT + l);
			if (pos < 7'(frrs_pkg::MASK_W)) begin
				type_mask[l] = lane_masks_q[pos[5:0]];
			end
		end
	end

	frrs_pick #(
		.LANE_COUNT (LANE_COUNT),
		.LW         (LW)
	) u_pick (
		.ptr  (ptr),
		.mask (type_mask),
		.pick (pick)
	);

	always_comb begin
		result = pick;
		if (!in_range_s1) begin
			result.lane    = '0;
			result.no_lane = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> s1_valid)
		else $error("input stalled with no item in the search stage");

	a_bypass_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> s1_valid)
		else $error("pointer bypass set with no item in the search stage");

	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s1_adv) |=> rsp_valid)
		else $error("item left the search stage without a result");

	a_lane_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.no_lane) |-> (int'(rsp_data.lane) < LANE_COUNT))
		else $error("chosen lane beyond issue width");

	a_write_only_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (rsp_valid && !rsp_data.no_lane))
		else $error("pointer written for an item that found no lane");

endmodule
